// File: design/channel_remap_table_builder_top_defines.svh
// Assertion macros for the channel remap table builder.
`ifndef CHANNEL_REMAP_TABLE_BUILDER_TOP_DEFINES_SVH
`define CHANNEL_REMAP_TABLE_BUILDER_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define CRTB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crtb assertion failed");

// Next-cycle implication, checked out of reset.
`define CRTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crtb assertion failed");

`else

`define CRTB_ASSERT_IMPL(label, ante, cons)
`define CRTB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/crtb_pkg.sv
// Shared types and constants of the channel remap table builder.
`timescale 1ns / 1ps

package crtb_pkg;

	localparam int MAX_CHANNELS_DEF   = 8;
	localparam int PLACEMENT_BITS_DEF = 18;
	localparam int FIELD_W            = 18;
	localparam int OUT_W              = 3;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SRC_UNKNOWN = 3'd1,
		ST_TGT_UNKNOWN = 3'd2,
		ST_DUP_SOURCE  = 3'd3,
		ST_TGT_MISSING = 3'd4,
		ST_TOO_MANY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] source_placement;
		logic [FIELD_W-1:0] target_placement;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] target_slot;
		logic [OUT_W-1:0] source_index;
		status_t          status;
		logic             end_of_table;
	} out_item_t;

	// Controls from the sequencer to every cell.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Match summary rippled from cell to cell.
	typedef struct packed {
		logic hit;
		logic dup;
		logic src_unk;
	} link_t;

endpackage

// File: design/channel_remap_table_builder_top.sv
// Top level of the channel remap table builder: config register, cell row and sequencer.
`timescale 1ns / 1ps
// Usage:
// Raise start with one channel word on item (source code, target code, last) while
// busy is low; the word is taken at that clock edge. Words without last leave busy
// low and are stored in the next free cell; words past MAX_CHANNELS are dropped and
// turn the table into a too-many error.
// On the word with last, busy rises. The check walks the target codes through the cell
// row, one slot per cycle, and stops early on an error. A clean table then goes out
// one word per cycle, one word per stored channel; result words are registered and
// appear in the cycle after the one that formed them. The block takes a new word once
// busy is low again. An error gives a single word with end_of_table set.
// Each result word is valid for the one cycle that result_strobe is high; the receiver
// cannot stall. The user must assert cfg_we to write unknown_code only while the block
// is idle; the block itself does not enforce it.
// Reset clears the fill count, the sequencer and unknown_code; no word is pending after.

module channel_remap_table_builder_top import crtb_pkg::*; #(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int PLACEMENT_BITS = PLACEMENT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_item_t           item,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata,
	output logic               result_strobe,
	output out_item_t          result
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

	logic [FIELD_W-1:0]        unknown_q;
	logic [PLACEMENT_BITS-1:0] unk_code;
	logic [PLACEMENT_BITS-1:0] src_code;
	logic [PLACEMENT_BITS-1:0] tgt_code;
	cell_ctl_t                 ctl;
	logic [CNT_W-1:0]          count;
	logic [PLACEMENT_BITS-1:0] tgt_chain [MAX_CHANNELS+1];
	link_t                     link_chain [MAX_CHANNELS+1];
	logic [IDX_W-1:0]          idx_chain [MAX_CHANNELS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unknown_q <= '0;
		end else if (cfg_we) begin
			unknown_q <= cfg_wdata;
		end
	end

	assign unk_code = PLACEMENT_BITS'(unknown_q);
	assign src_code = PLACEMENT_BITS'(item.source_placement);
	assign tgt_code = PLACEMENT_BITS'(item.target_placement);

	assign tgt_chain[MAX_CHANNELS] = '0;
	assign link_chain[0]           = '0;
	assign idx_chain[0]            = '0;

	for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
		crtb_cell #(
			.CELL_INDEX     (i),
			.PLACEMENT_BITS (PLACEMENT_BITS),
			.IDX_W          (IDX_W),
			.CNT_W          (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_ptr    (count),
			.count     (count),
			.src_code  (src_code),
			.tgt_code  (tgt_code),
			.unk_code  (unk_code),
			.probe     (tgt_chain[0]),
			.tgt_right (tgt_chain[i+1]),
			.tgt_out   (tgt_chain[i]),
			.link_in   (link_chain[i]),
			.idx_in    (idx_chain[i]),
			.link_out  (link_chain[i+1]),
			.idx_out   (idx_chain[i+1])
		);
	end

	crtb_ctrl #(
		.MAX_CHANNELS   (MAX_CHANNELS),
		.PLACEMENT_BITS (PLACEMENT_BITS),
		.IDX_W          (IDX_W),
		.CNT_W          (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.item_last     (item.last),
		.busy          (busy),
		.ctl           (ctl),
		.count         (count),
		.unk_code      (unk_code),
		.probe         (tgt_chain[0]),
		.chain_link    (link_chain[MAX_CHANNELS]),
		.chain_idx     (idx_chain[MAX_CHANNELS]),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

// File: design/crtb_cell.sv
// One channel cell: holds a source and a target code and joins the match ripple.
`timescale 1ns / 1ps

module crtb_cell import crtb_pkg::*; #(
	parameter int CELL_INDEX     = 0,
	parameter int PLACEMENT_BITS = PLACEMENT_BITS_DEF,
	parameter int IDX_W          = 3,
	parameter int CNT_W          = 4
) (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic [CNT_W-1:0]          wr_ptr,
	input  logic [CNT_W-1:0]          count,
	input  logic [PLACEMENT_BITS-1:0] src_code,
	input  logic [PLACEMENT_BITS-1:0] tgt_code,
	input  logic [PLACEMENT_BITS-1:0] unk_code,
	input  logic [PLACEMENT_BITS-1:0] probe,
	input  logic [PLACEMENT_BITS-1:0] tgt_right,
	output logic [PLACEMENT_BITS-1:0] tgt_out,
	input  link_t                     link_in,
	input  logic [IDX_W-1:0]          idx_in,
	output link_t                     link_out,
	output logic [IDX_W-1:0]          idx_out
);

	logic [PLACEMENT_BITS-1:0] src_q;
	logic [PLACEMENT_BITS-1:0] tgt_q;
	logic                      mine;
	logic                      valid;
	logic                      match;
	logic                      unk;

	assign mine  = (wr_ptr == CNT_W'(CELL_INDEX));
	assign valid = (CNT_W'(CELL_INDEX) < count);
	assign match = valid && (src_q == probe);
	assign unk   = valid && (src_q == unk_code);

	// Targets walk toward cell zero during the check, one slot per cycle.
	always_ff @(posedge clk) begin
		if (ctl.load && mine) begin
			src_q <= src_code;
			tgt_q <= tgt_code;
		end else if (ctl.shift) begin
			tgt_q <= tgt_right;
		end
	end

	assign tgt_out = tgt_q;

	// First matching source wins; a second one flags a duplicate.
	always_comb begin
		link_out.hit     = link_in.hit | match;
		link_out.dup     = link_in.dup | (link_in.hit & match);
		link_out.src_unk = link_in.src_unk | unk;
		idx_out          = (match && !link_in.hit) ? IDX_W'(CELL_INDEX) : idx_in;
	end

endmodule

// File: design/crtb_ctrl.sv
// Sequencer of the table builder: fill count, slot walk, map store and result register.
`timescale 1ns / 1ps
`include "channel_remap_table_builder_top_defines.svh"

module crtb_ctrl import crtb_pkg::*; #(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int PLACEMENT_BITS = PLACEMENT_BITS_DEF,
	parameter int IDX_W          = 3,
	parameter int CNT_W          = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      item_last,
	output logic                      busy,
	output cell_ctl_t                 ctl,
	output logic [CNT_W-1:0]          count,
	input  logic [PLACEMENT_BITS-1:0] unk_code,
	input  logic [PLACEMENT_BITS-1:0] probe,
	input  link_t                     chain_link,
	input  logic [IDX_W-1:0]          chain_idx,
	output logic                      result_strobe,
	output out_item_t                 result
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic [IDX_W-1:0] slot_q;
	logic             missing_q;
	logic [IDX_W-1:0] map_q [MAX_CHANNELS];
	logic             strobe_q;
	out_item_t        result_q;

	logic             accept;
	logic             room;
	logic             last_slot;
	logic             miss_any;
	status_t          check_err;
	logic             strobe_d;
	out_item_t        result_d;

	assign accept    = start && (state_q == S_IDLE);
	assign room      = (count_q != CNT_W'(MAX_CHANNELS));
	assign last_slot = ((CNT_W'(slot_q) + CNT_W'(1)) == count_q);
	assign miss_any  = missing_q || !chain_link.hit;

	// Error priority for the slot now at the head of the chain.
	always_comb begin
		if (overflow_q) begin
			check_err = ST_TOO_MANY;
		end else if (chain_link.src_unk) begin
			check_err = ST_SRC_UNKNOWN;
		end else if (probe == unk_code) begin
			check_err = ST_TGT_UNKNOWN;
		end else if (chain_link.dup) begin
			check_err = ST_DUP_SOURCE;
		end else begin
			check_err = ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (check_err != ST_OK) begin
					state_d = S_IDLE;
				end else if (last_slot) begin
					state_d = miss_any ? S_IDLE : S_EMIT;
				end
			end
			S_EMIT: begin
				if (last_slot) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.load  = 1'b0;
		ctl.shift = 1'b0;
		strobe_d  = 1'b0;
		result_d  = '{target_slot: '0, source_index: '0, status: ST_OK, end_of_table: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				ctl.load = accept && room;
			end
			S_CHECK: begin
				ctl.shift = 1'b1;
				if (check_err != ST_OK) begin
					strobe_d        = 1'b1;
					result_d.status = check_err;
				end else if (last_slot && miss_any) begin
					strobe_d        = 1'b1;
					result_d.status = ST_TGT_MISSING;
				end
			end
			S_EMIT: begin
				strobe_d              = 1'b1;
				result_d.target_slot  = OUT_W'(slot_q);
				result_d.source_index = OUT_W'(map_q[slot_q]);
				result_d.end_of_table = last_slot;
			end
			default: begin
				ctl.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			slot_q     <= '0;
			missing_q  <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			if (accept) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
				slot_q    <= '0;
				missing_q <= 1'b0;
			end else if (state_q == S_CHECK) begin
				missing_q <= miss_any;
				slot_q    <= last_slot ? '0 : slot_q + IDX_W'(1);
			end else if (state_q == S_EMIT) begin
				slot_q <= slot_q + IDX_W'(1);
			end
			// Drop the lists once the table or the error has gone out.
			if (state_q != S_IDLE && state_d == S_IDLE) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			map_q[slot_q] <= chain_idx;
		end
		result_q <= result_d;
	end

	assign busy          = (state_q != S_IDLE);
	assign count         = count_q;
	assign result_strobe = strobe_q;
	assign result        = result_q;

	`CRTB_ASSERT_IMPL(a_err_ends_table, strobe_q && result_q.status != ST_OK, result_q.end_of_table)
	`CRTB_ASSERT_IMPL(a_overflow_full, overflow_q, count_q == CNT_W'(MAX_CHANNELS))
	`CRTB_ASSERT_NEXT(a_emit_done, state_q == S_EMIT && last_slot, state_q == S_IDLE)
	`CRTB_ASSERT_IMPL(a_strobe_source, strobe_q, $past(state_q) == S_CHECK || $past(state_q) == S_EMIT)

endmodule
